/* rtl/mtfl_pkg.sv */
// shared types and constants for the move-to-front list cost block
// no dependencies; imported by mtfl_cell and move_to_front_list_cost
package mtfl_pkg;

    localparam int KEY_IN_W   = 8;
    localparam int POS_OUT_W  = 4;
    localparam int COST_OUT_W = 5;
    localparam int SUM_W      = 48;
    localparam int OUT_DATA_W = 64;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // per-cell controls issued by the sequencer each cycle
    typedef struct packed {
        logic restore;  // load the initial key for this slot
        logic shift;    // take the neighbor's entry (slot 0 takes the key)
    } mtfl_cell_ctrl_t;

endpackage

/* rtl/mtfl_cell.sv */
// one slot of the move-to-front list: entry register, key compare, search token
// depends on mtfl_pkg
module mtfl_cell
    import mtfl_pkg::*;
#(
    parameter int KEY_WIDTH = 8,
    parameter int INDEX     = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mtfl_cell_ctrl_t      ctrl,
    input  logic [KEY_IN_W-1:0]  key,
    input  logic [KEY_WIDTH-1:0] prev_entry,
    input  logic                 probe_in,
    output logic [KEY_WIDTH-1:0] entry,
    output logic                 hit,
    output logic                 probe_out
);

    localparam int CMP_W = (KEY_WIDTH > KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam logic [KEY_WIDTH-1:0] INIT_KEY = KEY_WIDTH'(INDEX + 1);

    logic [KEY_WIDTH-1:0] entry_reg;
    logic                 probe_reg;
    logic [CMP_W-1:0]     entry_cmp;
    logic [CMP_W-1:0]     key_cmp;
    logic                 match;

    assign entry_cmp = CMP_W'(entry_reg);
    assign key_cmp   = CMP_W'(key);
    assign match     = (entry_cmp == key_cmp);

    // token stops at the first matching slot, otherwise moves on next cycle
    assign hit       = probe_reg & match;
    assign probe_out = probe_reg & ~match;
    assign entry     = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= INIT_KEY;
            probe_reg <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_in;
            if (ctrl.restore)
            begin
                entry_reg <= INIT_KEY;
            end
            else if (ctrl.shift)
            begin
                entry_reg <= prev_entry;
            end
        end
    end

endmodule

/* rtl/move_to_front_list_cost.sv */
// Move-to-front list with access cost.
// Input channel s_*: one access request per beat, key in s_tdata, s_tuser set
// restores the list to 1..LIST_SIZE and clears the running total first.
// Output channel m_*: one result per request, found flag in m_tuser and
// position, access cost 2*pos+1 (both zero on a miss) and saturating 48-bit total in m_tdata.
// The list is a row of cells, one key each. A search token enters slot 0 the
// cycle after the request is taken and steps one slot per cycle until a slot
// matches or it falls off the end. On a hit, the commit shifts every slot up to
// the hit back by one and writes the key into slot 0 in a single step.
// An access is taken in ST_IDLE, searched in ST_SEARCH and written to the
// result register in ST_COMMIT. The next request is taken no earlier than the
// cycle after the commit, so the token walk sets the throughput.
// A finished result waits in the output register while the next request is
// taken and searched; commit waits until the output register is free.
// Reset loads keys 1..LIST_SIZE, clears the total and empties both channels.
// depends on mtfl_pkg and mtfl_cell
module move_to_front_list_cost
    import mtfl_pkg::*;
#(
    parameter int LIST_SIZE = 16,
    parameter int KEY_WIDTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEY_IN_W-1:0]   s_tdata,   // [7:0] key
    input  logic                  s_tuser,   // [0] start_sequence
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] position, [8:4] access_cost,
                                             // [56:9] total_cost, rest zero
    output logic                  m_tuser    // [0] found
);

    localparam int IW    = $clog2(LIST_SIZE);
    localparam int PAD_W = OUT_DATA_W - POS_OUT_W - COST_OUT_W - SUM_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    state_t                 state_reg;
    logic [KEY_IN_W-1:0]    key_reg;
    logic [IW-1:0]          scan_cnt_reg;
    logic [IW-1:0]          pos_reg;
    logic                   found_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [POS_OUT_W-1:0]   out_pos_reg;
    logic [COST_OUT_W-1:0]  out_cost_reg;
    logic [SUM_W-1:0]       out_total_reg;

    logic                   accept;
    logic                   commit_go;
    logic                   any_hit;
    logic                   miss;
    logic [IW:0]            cost_full;
    logic [SUM_W:0]         sum_add;
    logic [SUM_W-1:0]       sum_next;

    mtfl_cell_ctrl_t        cell_ctrl [LIST_SIZE];
    logic [KEY_WIDTH-1:0]   entry_w   [LIST_SIZE];
    logic [KEY_WIDTH-1:0]   prev_w    [LIST_SIZE];
    logic [LIST_SIZE-1:0]   hit_vec;
    logic [LIST_SIZE:0]     probe_w;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign commit_go = (state_reg == ST_COMMIT) & (~out_valid_reg | m_tready);
    assign probe_w[0] = accept;
    assign any_hit   = |hit_vec;
    assign miss      = probe_w[LIST_SIZE];

    genvar gi;
    generate
        for (gi = 0; gi < LIST_SIZE; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign prev_w[gi] = KEY_WIDTH'(key_reg);
            end
            else
            begin : g_body
                assign prev_w[gi] = entry_w[gi-1];
            end

            assign cell_ctrl[gi].restore = accept & s_tuser;
            assign cell_ctrl[gi].shift   = commit_go & found_reg & (IW'(gi) <= pos_reg);

            mtfl_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .INDEX     (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl[gi]),
                .key        (key_reg),
                .prev_entry (prev_w[gi]),
                .probe_in   (probe_w[gi]),
                .entry      (entry_w[gi]),
                .hit        (hit_vec[gi]),
                .probe_out  (probe_w[gi+1])
            );
        end
    endgenerate

    // total can only overflow through the carry since it never exceeds the max
    assign cost_full = {pos_reg, 1'b1};
    assign sum_add   = {1'b0, sum_reg} + (SUM_W+1)'(cost_full);

    always_comb
    begin
        if (!found_reg)
        begin
            sum_next = sum_reg;
        end
        else if (sum_add[SUM_W])
        begin
            sum_next = SUM_MAX;
        end
        else
        begin
            sum_next = sum_add[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_reg       <= '0;
            scan_cnt_reg  <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_cost_reg  <= '0;
            out_total_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg      <= s_tdata;
                        scan_cnt_reg <= '0;
                        if (s_tuser)
                        begin
                            sum_reg <= '0;
                        end
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (any_hit)
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= scan_cnt_reg;
                        state_reg <= ST_COMMIT;
                    end
                    else if (miss)
                    begin
                        found_reg <= 1'b0;
                        pos_reg   <= '0;
                        state_reg <= ST_COMMIT;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                ST_COMMIT:
                begin
                    if (commit_go)
                    begin
                        sum_reg       <= sum_next;
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_pos_reg   <= found_reg ? POS_OUT_W'(pos_reg) : '0;
                        out_cost_reg  <= found_reg ? COST_OUT_W'(cost_full) : '0;
                        out_total_reg <= sum_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_total_reg, out_cost_reg, out_pos_reg};

    // only one slot can stop the token
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("more than one slot hit in one cycle");

    // the token lives only while searching
    assert property (@(posedge clk) disable iff (!rst_n)
        (hit_vec != '0) |-> (state_reg == ST_SEARCH))
        else $error("slot hit outside search");

    // a taken request starts the walk at slot 0
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SEARCH) && (scan_cnt_reg == '0))
        else $error("search did not start at slot 0");

    // a commit always leaves a result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        commit_go |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("commit without result");

endmodule
